### design/mva_pkg.sv
// Shared types and constants for the MIDI voice allocator.
package mva_pkg;

  localparam int unsigned VOICES_DEF = 8;

  // Depth of the command queue between front and back; keep a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [1:0] LEN_FULL     = 2'd3;

  typedef struct packed {
    logic [7:0] msg_status;
    logic [7:0] first_data;
    logic [7:0] second_data;
    logic [1:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0] voice_index;
    logic       restart_life;
    logic       voice_on;
    logic [6:0] note_number;
    logic [3:0] channel_number;
    logic [6:0] key_velocity;
  } out_item_t;

  // Classified note command handed from front to back.
  typedef struct packed {
    logic       is_on;
    logic [6:0] note;
    logic [3:0] chan;
    logic [6:0] vel;
  } cmd_t;

  // Per-voice stored fields.
  typedef struct packed {
    logic [6:0] note;
    logic [3:0] chan;
    logic [6:0] vel;
  } voice_t;

endpackage

### design/mva_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mva_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/mva_front.sv
// Front end: takes a message, drops malformed or unrelated ones, forms a note command.
module mva_front (
  input  logic              start_i,
  input  logic              full_i,
  input  mva_pkg::in_item_t item_i,
  output logic              push_o,
  output mva_pkg::cmd_t     cmd_o
);
  import mva_pkg::*;

  logic [3:0] msg_type;
  logic       data_ok;
  logic       is_note;

  assign msg_type = item_i.msg_status[7:4];
  // Note commands need all three bytes, so both data bytes must have bit 7 clear.
  assign data_ok  = (item_i.byte_count == LEN_FULL) &&
                    !item_i.first_data[7] && !item_i.second_data[7];

  always_comb begin
    case (msg_type)
      MSG_NOTE_ON, MSG_NOTE_OFF: is_note = 1'b1;
      default:                   is_note = 1'b0;
    endcase
  end

  assign push_o      = start_i && !full_i && is_note && data_ok;
  assign cmd_o.is_on = (msg_type == MSG_NOTE_ON);
  assign cmd_o.note  = item_i.first_data[6:0];
  assign cmd_o.chan  = item_i.msg_status[3:0];
  assign cmd_o.vel   = item_i.second_data[6:0];

endmodule

### design/mva_queue.sv
// Short command queue between front and back.
module mva_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mva_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output mva_pkg::cmd_t cmd_o
);
  import mva_pkg::*;

  cmd_t           mem_q [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           do_pop;

  assign full_o  = (cnt_q == QCW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCW'(push_i) - QCW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCW'(QUEUE_DEPTH)) else $error("queue count out of range");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not follow push");

endmodule

### design/mva_back.sv
// Back end: scans voices one per cycle, claims or releases a voice, emits the update.
module mva_back #(
  parameter int unsigned VOICES = mva_pkg::VOICES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  mva_pkg::cmd_t      q_cmd_i,
  output logic               q_pop_o,
  output logic               res_valid_o,
  output mva_pkg::out_item_t res_o
);
  import mva_pkg::*;

  localparam int unsigned IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW = $clog2(VOICES + 1);
  localparam logic [CW-1:0] CNT_END = CW'(VOICES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic            st_q, st_d;
  cmd_t            cmd_q, cmd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            chk_vld_q, chk_vld_d;
  logic [IW-1:0]   chk_idx_q, chk_idx_d;
  logic [VOICES-1:0] active_q, active_d;
  logic            res_vld_q, res_vld_d;
  out_item_t       res_q, res_d;

  logic [IW-1:0]   scan_idx;
  logic            scan_end;
  logic            hit_on, hit_off;
  voice_t          rd_data;
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  voice_t          ram_wdata;

  assign scan_idx = cnt_q[IW-1:0];
  assign scan_end = (cnt_q == CNT_END);
  assign hit_on   = !scan_end && !active_q[scan_idx];
  // Read data is registered; check the voice whose address was issued last cycle.
  assign hit_off  = chk_vld_q && active_q[chk_idx_q] &&
                    (rd_data.note == cmd_q.note) && (rd_data.chan == cmd_q.chan);

  mva_ram #(
    .WIDTH ($bits(voice_t)),
    .DEPTH (VOICES),
    .AW    (IW)
  ) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_idx),
    .rdata_o (rd_data)
  );

  always_comb begin
    st_d      = st_q;
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    active_d  = active_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = scan_idx;
    ram_wdata = '{note: cmd_q.note, chan: cmd_q.chan, vel: cmd_q.vel};
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          cnt_d   = '0;
          st_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cmd_q.is_on) begin
          if (hit_on) begin
            active_d[scan_idx] = 1'b1;
            ram_we             = 1'b1;
            res_vld_d          = 1'b1;
            res_d = '{voice_index: 3'(scan_idx), restart_life: 1'b1, voice_on: 1'b1,
                      note_number: cmd_q.note, channel_number: cmd_q.chan,
                      key_velocity: cmd_q.vel};
            st_d  = ST_IDLE;
          end else if (scan_end) begin
            st_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          if (hit_off) begin
            active_d[chk_idx_q] = 1'b0;
            ram_we              = 1'b1;
            ram_waddr           = chk_idx_q;
            ram_wdata = '{note: rd_data.note, chan: rd_data.chan, vel: cmd_q.vel};
            res_vld_d           = 1'b1;
            res_d = '{voice_index: 3'(chk_idx_q), restart_life: 1'b0, voice_on: 1'b0,
                      note_number: rd_data.note, channel_number: rd_data.chan,
                      key_velocity: cmd_q.vel};
            st_d  = ST_IDLE;
          end else if (scan_end) begin
            st_d = ST_IDLE;
          end else begin
            chk_vld_d = 1'b1;
            chk_idx_d = scan_idx;
            cnt_d     = cnt_q + 1'b1;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      active_q  <= '0;
      res_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= chk_vld_d;
      active_q  <= active_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    chk_idx_q <= chk_idx_d;
    res_q     <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  a_res_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> $past(st_q == ST_SCAN)) else $error("result without a scan");

  a_single_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |=> !res_vld_q) else $error("two results in a row");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN) |-> (cnt_q <= CNT_END)) else $error("scan counter overrun");

  a_on_sets_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN && cmd_q.is_on && hit_on) |=> ($countones(active_q) ==
      $countones($past(active_q)) + 1)) else $error("claim did not mark voice");

endmodule

### design/midi_voice_allocator.sv
// Top level of the MIDI polyphonic voice allocator.
//
//  channel | ports                       | handshake
//  --------+-----------------------------+-------------------------------------
//  message | start, busy, item_i         | taken when start=1 and busy=0
//  update  | result_valid_o, result_o    | one-cycle strobe, no backpressure
//
// The front classifies a message in the cycle it is taken and pushes note-on /
// note-off commands into a two-entry queue; all other messages are dropped there.
// The back pops a command and scans the voices one per cycle through the voice
// RAM port, and pops no new command until that scan has ended. busy is high only
// while the queue is full; results appear in the cycle after the deciding scan
// step. Reset clears the active marks; stored fields need none.
module midi_voice_allocator #(
  parameter int unsigned VOICES = mva_pkg::VOICES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mva_pkg::in_item_t  item_i,
  output logic               result_valid_o,
  output mva_pkg::out_item_t result_o
);
  import mva_pkg::*;

  logic full;
  logic push;
  cmd_t push_cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  assign busy = full;

  // Classify and filter incoming messages.
  mva_front u_front (
    .start_i (start),
    .full_i  (full),
    .item_i  (item_i),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  // Decouples message intake from the voice scan.
  mva_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (q_pop),
    .full_o  (full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // Voice scan, state update and result register.
  mva_back #(
    .VOICES (VOICES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule
